// ----- rtl/max_flow_bfs_augmenting_top_macros.svh -----
// Assertion macros for the top-level RTL file.
`ifndef MAX_FLOW_BFS_AUGMENTING_TOP_MACROS_SVH
`define MAX_FLOW_BFS_AUGMENTING_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MFB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define MFB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MFB_ASSERT_IMP(lbl, ante, cons, msg)
`define MFB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mfb_pkg.sv -----
package mfb_pkg;
	localparam int NODE_COUNT_DEF    = 64;
	localparam int CAPACITY_BITS_DEF = 16;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SOLVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_SINK   = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  edge_from;
		logic [5:0]  edge_to;
		logic [15:0] edge_capacity;
	} item_t;

	typedef struct packed {
		logic [31:0] flow_value;
		logic        status;
	} result_t;
endpackage

// ----- rtl/mfb_ram.sv -----
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/max_flow_bfs_augmenting_top.sv -----
// Maximum flow engine (Edmonds-Karp) over a residual capacity matrix.
// Channels: item (valid/ready) carries load, solve and clear commands;
// result (valid/ready) carries one beat per solve: flow value and status;
// cfg (valid/ready, always ready) writes source node (index 0) and sink
// node (index 1); the user must write only while the block is idle, as the
// block itself does not enforce it. A clear sweeps the matrix one entry a
// cycle; the same sweep runs after reset before the first item is taken.
// A solve runs breadth-first searches one after another. Each search clears
// the visited memory and scans one matrix row per dequeued node at one
// entry a cycle through the single matrix read port. Each augmenting path
// is then walked back from the sink twice: once to find its smallest
// residual, once to take it from each forward entry and add it, saturating,
// to each backward entry. Source equal to sink (status set) or a terminal
// outside NODE_COUNT (status clear) skips the search with zero flow.
// The result sits in an output register; loads and clears are taken while
// it waits. A second solve finishing while the receiver stalls holds until
// the waiting beat is taken.
`include "max_flow_bfs_augmenting_top_macros.svh"
module max_flow_bfs_augmenting_top
	import mfb_pkg::*;
#(
	parameter int NODE_COUNT    = NODE_COUNT_DEF,
	parameter int CAPACITY_BITS = CAPACITY_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_index,
	input  logic [5:0] cfg_data
);
	localparam int NB = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int AB = 2 * NB;
	localparam int RW = CAPACITY_BITS + 1;
	localparam logic [RW-1:0] RES_MAX = {RW{1'b1}};
	localparam logic [NB:0]   N_CNT   = (NB+1)'(NODE_COUNT);
	localparam logic [NB-1:0] N_LAST  = NB'(NODE_COUNT - 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_VCLR = 4'd2;
	localparam logic [3:0] S_INIT = 4'd3;
	localparam logic [3:0] S_DEQ  = 4'd4;
	localparam logic [3:0] S_DEQW = 4'd5;
	localparam logic [3:0] S_SCAN = 4'd6;
	localparam logic [3:0] S_CHK  = 4'd7;
	localparam logic [3:0] S_M1   = 4'd8;
	localparam logic [3:0] S_M2   = 4'd9;
	localparam logic [3:0] S_M3   = 4'd10;
	localparam logic [3:0] S_U1   = 4'd11;
	localparam logic [3:0] S_U2   = 4'd12;
	localparam logic [3:0] S_U3   = 4'd13;
	localparam logic [3:0] S_U4   = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	logic [3:0]    state_q;
	logic [5:0]    src_q, dst_q;
	logic [AB-1:0] clr_q;
	logic [NB-1:0] vclr_q;
	logic [NB:0]   head_q, tail_q, scan_v_q;
	logic          pend_s1;
	logic [NB-1:0] pend_v_s1;
	logic [NB-1:0] u_q, v_q;
	logic [RW-1:0] amt_q;
	logic [31:0]   total_q;
	logic          status_q;
	logic          result_valid_q;
	result_t       result_q;

	logic          res_we;
	logic [AB-1:0] res_waddr, res_raddr;
	logic [RW-1:0] res_wdata, res_rdata;
	logic          vis_we, vis_wdata, vis_rdata;
	logic [NB-1:0] vis_waddr, vis_raddr;
	logic          pred_we;
	logic [NB-1:0] pred_waddr, pred_wdata, pred_raddr, pred_rdata;
	logic          q_we;
	logic [NB-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

	logic [NB-1:0] src_n, dst_n;
	logic          take_item, load_ok, found;
	logic [RW:0]   bsum;
	logic [32:0]   tsum;
	logic          res_done;

	assign src_n      = NB'(src_q);
	assign dst_n      = NB'(dst_q);
	assign item_ready = (state_q == S_IDLE);
	assign take_item  = item_valid && item_ready;
	assign load_ok    = (item.edge_from < NODE_COUNT) && (item.edge_to < NODE_COUNT);
	assign found      = pend_s1 && !vis_rdata && (res_rdata != '0);
	assign bsum       = {1'b0, res_rdata} + {1'b0, amt_q};
	assign tsum       = {1'b0, total_q} + 33'(amt_q);
	assign res_done   = result_valid_q && result_ready;
	assign cfg_ready  = 1'b1;
	assign result_valid = result_valid_q;
	assign result     = result_q;

	// steer the memory ports by state
	always_comb begin
		res_we     = 1'b0;
		res_waddr  = clr_q;
		res_wdata  = '0;
		res_raddr  = {u_q, scan_v_q[NB-1:0]};
		vis_we     = 1'b0;
		vis_waddr  = vclr_q;
		vis_wdata  = 1'b0;
		vis_raddr  = scan_v_q[NB-1:0];
		pred_we    = 1'b0;
		pred_waddr = pend_v_s1;
		pred_wdata = u_q;
		pred_raddr = v_q;
		q_we       = 1'b0;
		q_waddr    = tail_q[NB-1:0];
		q_wdata    = pend_v_s1;
		q_raddr    = head_q[NB-1:0];
		case (state_q)
			S_CLR: begin
				res_we = 1'b1;
			end
			S_IDLE: begin
				res_we    = take_item && (item.action == ACT_LOAD) && load_ok;
				res_waddr = {NB'(item.edge_from), NB'(item.edge_to)};
				res_wdata = RW'(CAPACITY_BITS'(item.edge_capacity));
			end
			S_VCLR: begin
				vis_we = 1'b1;
			end
			S_INIT: begin
				vis_we     = 1'b1;
				vis_waddr  = src_n;
				vis_wdata  = 1'b1;
				pred_we    = 1'b1;
				pred_waddr = src_n;
				pred_wdata = src_n;
				q_we       = 1'b1;
				q_waddr    = '0;
				q_wdata    = src_n;
			end
			S_DEQ: begin
				vis_raddr = dst_n;
			end
			S_SCAN: begin
				vis_we    = found;
				vis_waddr = pend_v_s1;
				vis_wdata = 1'b1;
				pred_we   = found;
				q_we      = found && (tail_q < N_CNT);
			end
			S_M2, S_U2: begin
				res_raddr = {pred_rdata, v_q};
			end
			S_U3: begin
				res_we    = 1'b1;
				res_waddr = {u_q, v_q};
				res_wdata = res_rdata - amt_q;
				res_raddr = {v_q, u_q};
			end
			S_U4: begin
				res_we    = 1'b1;
				res_waddr = {v_q, u_q};
				res_wdata = bsum[RW] ? RES_MAX : bsum[RW-1:0];
			end
			default: begin
			end
		endcase
	end

	// hold the source and sink registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= 6'd0;
			dst_q <= 6'd1;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SOURCE) src_q <= cfg_data;
			if (cfg_index == REG_SINK)   dst_q <= cfg_data;
		end
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			vclr_q         <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			scan_v_q       <= '0;
			pend_s1        <= 1'b0;
			pend_v_s1      <= '0;
			u_q            <= '0;
			v_q            <= '0;
			amt_q          <= '0;
			result_valid_q <= 1'b0;
			total_q        <= '0;
			status_q       <= 1'b0;
		end else begin
			if (res_done) result_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {AB{1'b1}}) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (take_item) begin
						case (item.action)
							ACT_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLR;
							end
							ACT_SOLVE: begin
								total_q  <= '0;
								status_q <= (src_q == dst_q);
								vclr_q   <= '0;
								if (src_q == dst_q || src_q >= NODE_COUNT
									|| dst_q >= NODE_COUNT) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_VCLR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_VCLR: begin
					vclr_q <= vclr_q + 1'b1;
					if (vclr_q == N_LAST) state_q <= S_INIT;
				end
				S_INIT: begin
					head_q  <= '0;
					tail_q  <= (NB+1)'(1);
					state_q <= S_DEQ;
				end
				S_DEQ: begin
					if (head_q == tail_q) begin
						state_q <= S_CHK;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_DEQW;
					end
				end
				S_DEQW: begin
					u_q      <= q_rdata;
					scan_v_q <= '0;
					pend_s1  <= 1'b0;
					state_q  <= S_SCAN;
				end
				S_SCAN: begin
					if (found && tail_q < N_CNT) tail_q <= tail_q + 1'b1;
					pend_v_s1 <= scan_v_q[NB-1:0];
					if (scan_v_q < N_CNT) begin
						pend_s1  <= 1'b1;
						scan_v_q <= scan_v_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) state_q <= S_DEQ;
					end
				end
				S_CHK: begin
					v_q   <= dst_n;
					amt_q <= RES_MAX;
					state_q <= vis_rdata ? S_M1 : S_DONE;
				end
				S_M1: begin
					if (v_q == src_n) begin
						v_q     <= dst_n;
						state_q <= S_U1;
					end else begin
						state_q <= S_M2;
					end
				end
				S_M2: begin
					u_q     <= pred_rdata;
					state_q <= S_M3;
				end
				S_M3: begin
					if (res_rdata < amt_q) amt_q <= res_rdata;
					v_q     <= u_q;
					state_q <= S_M1;
				end
				S_U1: begin
					if (v_q == src_n) begin
						total_q <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
						vclr_q  <= '0;
						state_q <= S_VCLR;
					end else begin
						state_q <= S_U2;
					end
				end
				S_U2: begin
					u_q     <= pred_rdata;
					state_q <= S_U3;
				end
				S_U3: begin
					state_q <= S_U4;
				end
				S_U4: begin
					v_q     <= u_q;
					state_q <= S_U1;
				end
				S_DONE: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// load the result beat
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!result_valid_q || result_ready)) begin
			result_q.flow_value <= total_q;
			result_q.status     <= status_q;
		end
	end

	mfb_ram #(.WIDTH(RW), .DEPTH(1 << AB)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr(res_raddr), .rdata(res_rdata)
	);
	mfb_ram #(.WIDTH(1), .DEPTH(1 << NB)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rdata)
	);
	mfb_ram #(.WIDTH(NB), .DEPTH(1 << NB)) u_pred (
		.clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
		.raddr(pred_raddr), .rdata(pred_rdata)
	);
	mfb_ram #(.WIDTH(NB), .DEPTH(1 << NB)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	`MFB_ASSERT_IMP(a_tail_bound, state_q == S_SCAN, tail_q <= N_CNT, "queue tail past node count")
	`MFB_ASSERT_IMP(a_head_tail, state_q == S_DEQ, head_q <= tail_q, "queue head passed tail")
	`MFB_ASSERT_IMP(a_no_underflow, state_q == S_U3, res_rdata >= amt_q, "path amount above residual")
	`MFB_ASSERT_NXT(a_result_src, !result_valid_q && state_q != S_DONE, !result_valid_q, "result beat without a finished solve")
endmodule

// ----- tb/max_flow_bfs_augmenting_top_test.sv -----
module max_flow_bfs_augmenting_top_test;
	import mfb_pkg::*;

	localparam int NODES = NODE_COUNT_DEF;
	localparam int CAP_W = CAPACITY_BITS_DEF;
	localparam logic [CAP_W:0] RESIDUAL_MAX = '1;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int LONG_HOLD_CYCLES = 30000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_SOURCE;
	logic [5:0] cfg_data = '0;

	max_flow_bfs_augmenting_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the block: residual matrix, terminals, search scratch
	logic [CAP_W:0] residual [NODES][NODES];
	logic [5:0] flow_src = 6'd0;
	logic [5:0] flow_dst = 6'd1;
	bit seen [NODES];
	int parent [NODES];

	item_t pending_items[$];
	result_t expected_flows[$];
	int error_count = 0;
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// Breadth-first search over positive residuals, ascending neighbor order
	function automatic bit find_augmenting_path();
		int order [NODES];
		int head;
		int tail;
		int u;
		head = 0;
		tail = 0;
		foreach (seen[i]) seen[i] = 1'b0;
		order[tail++] = int'(flow_src);
		seen[flow_src] = 1'b1;
		parent[flow_src] = int'(flow_src);
		while (head < tail) begin
			u = order[head++];
			for (int v = 0; v < NODES; v++) begin
				if (!seen[v] && residual[u][v] != 0) begin
					seen[v] = 1'b1;
					parent[v] = u;
					if (tail < NODES) order[tail++] = v;
				end
			end
		end
		return seen[flow_dst];
	endfunction

	function automatic logic [31:0] max_flow_total();
		longint unsigned total;
		logic [CAP_W:0] amount;
		int u;
		int v;
		total = 0;
		while (find_augmenting_path()) begin
			amount = RESIDUAL_MAX;
			for (v = int'(flow_dst); v != int'(flow_src); v = parent[v]) begin
				u = parent[v];
				if (residual[u][v] < amount) amount = residual[u][v];
			end
			for (v = int'(flow_dst); v != int'(flow_src); v = parent[v]) begin
				u = parent[v];
				residual[u][v] = residual[u][v] - amount;
				if (residual[v][u] > RESIDUAL_MAX - amount) residual[v][u] = RESIDUAL_MAX;
				else residual[v][u] = residual[v][u] + amount;
			end
			total += amount;
			if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
		end
		return total[31:0];
	endfunction

	function automatic void apply_command(input item_t cmd);
		result_t r;
		case (cmd.action)
			ACT_LOAD: begin
				residual[cmd.edge_from][cmd.edge_to] = {1'b0, cmd.edge_capacity};
			end
			ACT_CLEAR: begin
				foreach (residual[i, j]) residual[i][j] = '0;
			end
			ACT_SOLVE: begin
				if (flow_src == flow_dst) begin
					r.flow_value = '0;
					r.status = 1'b1;
				end else begin
					r.flow_value = max_flow_total();
					r.status = 1'b0;
				end
				expected_flows = {expected_flows, r};
			end
			default: ;
		endcase
	endfunction

	// Append one command to the driver's queue
	function automatic void queue_cmd(input item_t cmd);
		pending_items = {pending_items, cmd};
	endfunction

	// Driver: hold each beat until taken, insert random idle bursts
	int tx_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			tx_gap <= 0;
		end else if (!item_valid || item_ready) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				item_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				tx_gap <= $urandom_range(1, 18);
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item <= pending_items[0];
				apply_command(pending_items.pop_front());
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: stall at random, once for a long stretch, and check each beat
	int rx_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_gap <= 0;
			hold_left <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_flows.size() == 0) begin
					flag_mismatch("result beat with nothing expected");
				end else begin
					want = expected_flows.pop_front();
					if (result.flow_value !== want.flow_value)
						flag_mismatch($sformatf("flow_value got %0d want %0d",
							result.flow_value, want.flow_value));
					if (result.status !== want.status)
						flag_mismatch($sformatf("status got %0b want %0b",
							result.status, want.status));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (long_hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD_CYCLES;
				result_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				result_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				rx_gap <= $urandom_range(1, 18);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic item_t make_cmd(input logic [1:0] act, input int a, input int b,
			input int cap);
		item_t c;
		c.action = act;
		c.edge_from = a[5:0];
		c.edge_to = b[5:0];
		c.edge_capacity = cap[15:0];
		return c;
	endfunction

	function automatic int pick_capacity();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(1, 9);
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	// Wait for the last result, then let the block settle before a register write
	task automatic wait_idle();
		while (pending_items.size() > 0 || item_valid || expected_flows.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [5:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_SOURCE) flow_src = data;
		else flow_dst = data;
		@(posedge clk);
	endtask

	initial begin
		int sent;
		int nodes [6];
		int n_edges;
		logic [5:0] s;
		logic [5:0] d;
		foreach (residual[i, j]) residual[i][j] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, self loop, overwrite, unused action, clear
		queue_cmd(make_cmd(ACT_LOAD, 0, 1, 16'hFFFF));
		queue_cmd(make_cmd(ACT_LOAD, 0, 2, 0));
		queue_cmd(make_cmd(ACT_LOAD, 1, 1, 5));
		queue_cmd(make_cmd(ACT_LOAD, 2, 1, 7));
		queue_cmd(make_cmd(ACT_LOAD, 0, 2, 3));
		queue_cmd(make_cmd(ACT_LOAD, 0, 63, 1));
		queue_cmd(make_cmd(ACT_LOAD, 63, 1, 16'hFFFF));
		queue_cmd(make_cmd(ACT_LOAD, 63, 63, 16'hFFFF));
		queue_cmd(make_cmd(ACT_UNUSED, 63, 63, 16'hFFFF));
		queue_cmd(make_cmd(ACT_SOLVE, 0, 0, 0));
		queue_cmd(make_cmd(ACT_SOLVE, 63, 63, 16'hFFFF));
		queue_cmd(make_cmd(ACT_LOAD, 1, 0, 16'hFFFF));
		queue_cmd(make_cmd(ACT_CLEAR, 0, 0, 0));
		queue_cmd(make_cmd(ACT_SOLVE, 0, 0, 0));
		wait_idle();
		write_reg(REG_SOURCE, 6'd63);
		write_reg(REG_SINK, 6'd63);
		queue_cmd(make_cmd(ACT_LOAD, 63, 0, 16'hFFFF));
		queue_cmd(make_cmd(ACT_SOLVE, 0, 0, 0));
		wait_idle();
		write_reg(REG_SINK, 6'd0);
		queue_cmd(make_cmd(ACT_SOLVE, 0, 0, 0));
		sent = 18;

		// Random phases: small graphs around the terminals, plus noise
		for (int phase = 0; sent < 650; phase++) begin
			wait_idle();
			if (sent > 580) quiet = 1'b1;
			case ($urandom_range(0, 7))
				0: begin s = 6'd0; d = 6'd63; end
				1: begin s = 6'd63; d = 6'd0; end
				2: begin s = 6'($urandom_range(0, 63)); d = s; end
				default: begin
					s = 6'($urandom_range(0, 63));
					d = 6'($urandom_range(0, 63));
				end
			endcase
			write_reg(REG_SOURCE, s);
			write_reg(REG_SINK, d);
			nodes[0] = int'(s);
			nodes[1] = int'(d);
			for (int k = 2; k < 6; k++) nodes[k] = $urandom_range(0, 63);
			if ($urandom_range(0, 5) == 0) begin
				queue_cmd(make_cmd(ACT_CLEAR, $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 16'hFFFF)));
				sent++;
			end
			n_edges = $urandom_range(6, 14);
			for (int k = 0; k < n_edges; k++) begin
				case ($urandom_range(0, 19))
					0: queue_cmd(make_cmd(ACT_UNUSED, $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 16'hFFFF)));
					1, 2: begin
						queue_cmd(make_cmd(ACT_LOAD, $urandom_range(0, 63),
							$urandom_range(0, 63), pick_capacity()));
						sent++;
					end
					default: begin
						queue_cmd(make_cmd(ACT_LOAD, nodes[$urandom_range(0, 5)],
							nodes[$urandom_range(0, 5)], pick_capacity()));
						sent++;
					end
				endcase
			end
			if (phase == 3) long_hold_req = 1'b1;
			queue_cmd(make_cmd(ACT_SOLVE, $urandom_range(0, 63),
				$urandom_range(0, 63), $urandom_range(0, 16'hFFFF)));
			sent++;
			// Back-to-back solves, with loads behind them in phase 3, to fill the block
			if (phase == 3 || $urandom_range(0, 5) == 0) begin
				queue_cmd(make_cmd(ACT_SOLVE, 0, 0, 0));
				if (phase == 3) begin
					for (int k = 0; k < 4; k++)
						queue_cmd(make_cmd(ACT_LOAD, nodes[$urandom_range(0, 5)],
							nodes[$urandom_range(0, 5)], pick_capacity()));
					queue_cmd(make_cmd(ACT_SOLVE, 0, 0, 0));
					sent += 5;
				end
				sent++;
			end
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#200000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mfb_pkg.sv
rtl/mfb_ram.sv
rtl/max_flow_bfs_augmenting_top.sv
tb/max_flow_bfs_augmenting_top_test.sv
